FILE: hw/rtl/rd_pkg.sv
// ---------------------------------------------------------------------------
// rd_pkg: shared types for the restoring divider
// Beat payload structs for the operand and result channels.
// ---------------------------------------------------------------------------
`default_nettype none

package rd_pkg;

  localparam int FIELD_W = 32;

  typedef struct packed {
    logic [FIELD_W-1:0] dividend;
    logic [FIELD_W-1:0] divisor;
  } rd_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] quotient;
    logic [FIELD_W-1:0] remainder;
  } rd_out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/restoring_divider_top.sv
// An accepted operand beat passes every stage register in turn to its result.
// Throughput: one beat per cycle unless out_ready stalls the pipeline; each stage computes one quotient bit.
// Stages hold on a stall and bubbles collapse, so operands are still taken
// while a finished result waits on out_ready, as long as a stage is empty.
// Reset (rst_n low, synchronous) clears every stage valid bit; the data
// registers are not reset.
// ---------------------------------------------------------------------------
// restoring_divider_top: pipelined unsigned restoring divider
// WIDTH-stage pipeline, one restoring step per stage, valid/ready both sides.
// ---------------------------------------------------------------------------
`default_nettype none

module restoring_divider_top
  import rd_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire rd_in_t  in_data,
  input  wire logic    out_ready,
  output logic         out_valid,
  output rd_out_t      out_data
);

  // Chain of stage boundaries: index 0 is the input, index WIDTH the last
  // stage's registers, which double as the output register.
  logic             vld   [0:WIDTH];
  logic             rdy   [0:WIDTH];
  logic [WIDTH-1:0] rem_c [0:WIDTH];
  logic [WIDTH-1:0] dq_c  [0:WIDTH];
  logic [WIDTH-1:0] dvs_c [0:WIDTH];

  // Fit the 32-bit fields to WIDTH: truncate when narrower, zero-extend when
  // wider (bits above the field are zero).
  generate
    if (WIDTH <= FIELD_W) begin : g_in_narrow
      assign dq_c[0]  = in_data.dividend[WIDTH-1:0];
      assign dvs_c[0] = in_data.divisor[WIDTH-1:0];
    end else begin : g_in_wide
      assign dq_c[0]  = {{(WIDTH-FIELD_W){1'b0}}, in_data.dividend};
      assign dvs_c[0] = {{(WIDTH-FIELD_W){1'b0}}, in_data.divisor};
    end
  endgenerate

  assign vld[0]   = in_valid;
  assign in_ready = rdy[0];
  assign rem_c[0] = '0;

  // One stage per quotient bit, MSB first. A stage's ready is "empty or the
  // next one moves", so the ready path ripples back through all stages.
  generate
    for (genvar s = 0; s < WIDTH; s++) begin : g_stage
      rd_stage #(
        .WIDTH (WIDTH)
      ) u_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (vld[s]),
        .up_ready (rdy[s]),
        .rem_in   (rem_c[s]),
        .dq_in    (dq_c[s]),
        .dvs_in   (dvs_c[s]),
        .dn_valid (vld[s+1]),
        .dn_ready (rdy[s+1]),
        .rem_out  (rem_c[s+1]),
        .dq_out   (dq_c[s+1]),
        .dvs_out  (dvs_c[s+1])
      );
    end
  endgenerate

  assign rdy[WIDTH] = out_ready;
  assign out_valid  = vld[WIDTH];

  // After WIDTH shifts the dividend register holds the quotient. Divisor of
  // zero falls out naturally: every step keeps, giving all-ones / dividend.
  generate
    if (WIDTH >= FIELD_W) begin : g_out_wide
      assign out_data.quotient  = dq_c[WIDTH][FIELD_W-1:0];
      assign out_data.remainder = rem_c[WIDTH][FIELD_W-1:0];
    end else begin : g_out_narrow
      assign out_data.quotient  = {{(FIELD_W-WIDTH){1'b0}}, dq_c[WIDTH]};
      assign out_data.remainder = {{(FIELD_W-WIDTH){1'b0}}, rem_c[WIDTH]};
    end
  endgenerate

endmodule

`default_nettype wire

FILE: hw/rtl/rd_stage.sv
// ---------------------------------------------------------------------------
// rd_stage: one restoring division step
// Shift in the next dividend bit, trial-subtract, keep or restore; registered.
// ---------------------------------------------------------------------------
`default_nettype none

module rd_stage #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire logic [WIDTH-1:0] rem_in,
  input  wire logic [WIDTH-1:0] dq_in,
  input  wire logic [WIDTH-1:0] dvs_in,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output logic [WIDTH-1:0]      rem_out,
  output logic [WIDTH-1:0]      dq_out,
  output logic [WIDTH-1:0]      dvs_out
);

  logic             valid_r;
  logic [WIDTH-1:0] rem_r, dq_r, dvs_r;
  logic [WIDTH-1:0] rem_nxt, dq_nxt;
  logic [WIDTH:0]   part, diff;
  logic             qbit;

  // partial remainder is WIDTH+1 bits wide
  assign part    = {rem_in, dq_in[WIDTH-1]};
  assign diff    = part - {1'b0, dvs_in};
  assign qbit    = ~diff[WIDTH];
  assign rem_nxt = qbit ? diff[WIDTH-1:0] : part[WIDTH-1:0];
  // dividend bits leave at the top, quotient bits enter at the bottom
  assign dq_nxt  = {dq_in[WIDTH-2:0], qbit};

  assign up_ready = ~valid_r | dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
      dvs_r <= dvs_in;
    end
  end

  assign dn_valid = valid_r;
  assign rem_out  = rem_r;
  assign dq_out   = dq_r;
  assign dvs_out  = dvs_r;

endmodule

`default_nettype wire

FILE: hw/rtl/rd_checker.sv
// ---------------------------------------------------------------------------
// rd_checker: port-level checks for the restoring divider
// Reset, stall hold and backpressure relations seen at the top-level ports.
// ---------------------------------------------------------------------------
`default_nettype none

module rd_checker
  import rd_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst_n,
  input wire logic    in_valid,
  input wire logic    in_ready,
  input wire rd_in_t  in_data,
  input wire logic    out_ready,
  input wire logic    out_valid,
  input wire rd_out_t out_data
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled operand beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("operand beat changed while stalled");

  // a stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // input may only back up when the pipeline is full behind a stalled output
  a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with room in the pipeline");

  // a draining output frees room for a new operand beat
  a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input not ready while output drains");

endmodule

bind restoring_divider_top rd_checker u_rd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_ready (out_ready),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire

FILE: test/restoring_divider_top_test.sv
// ---------------------------------------------------------------------------
// restoring_divider_top_test: self-checking bench for the pipelined divider
// Drives operand beats under random back-pressure on both channels. Each
// accepted beat is divided by a bit-serial restoring model, and every result
// beat is checked in order against the oldest pending quotient/remainder.
// ---------------------------------------------------------------------------
module restoring_divider_top_test;
  import rd_pkg::*;

  localparam int WIDTH      = 32;
  localparam int CLK_PERIOD = 8;
  localparam int RST_CYCLES = 12;
  // Pipeline depth; used for the quiet time at the end of the run.
  localparam int LATENCY    = WIDTH;
  localparam int WATCHDOG_CYCLES = 200000;

  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  logic    in_ready;
  rd_in_t  in_data   = '0;
  logic    out_ready = 1'b0;
  logic    out_valid;
  rd_out_t out_data;

  // Percent of cycles in which each side holds off.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Quotient/remainder pairs still owed by the pipeline, oldest first.
  rd_out_t pending_results[$];
  int unsigned mismatch_count = 0;

  restoring_divider_top #(
    .WIDTH(WIDTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Bit-serial restoring division. The partial remainder carries one extra
  // bit so the shifted value can exceed the divisor before the compare.
  // A zero divisor never fails the compare: all-ones quotient, remainder
  // equal to the dividend.
  function automatic rd_out_t divide_expected(input rd_in_t beat);
    logic [WIDTH-1:0] dvd;
    logic [WIDTH-1:0] dvs;
    logic [WIDTH-1:0] quo;
    logic [WIDTH:0]   part;
    rd_out_t          res;
    dvd  = beat.dividend[WIDTH-1:0];
    dvs  = beat.divisor[WIDTH-1:0];
    quo  = '0;
    part = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      part = {part[WIDTH-1:0], dvd[i]};
      if (part >= {1'b0, dvs}) begin
        part   = part - {1'b0, dvs};
        quo[i] = 1'b1;
      end
    end
    res           = '0;
    res.quotient  = quo;
    res.remainder = part[WIDTH-1:0];
    return res;
  endfunction

  // Receiver: random stalls, one update per edge.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Handshake monitor. Sampled at the edge, so both sides see the values
  // the DUT registered on.
  always @(posedge clk) begin
    rd_out_t want;
    if (rst_n && in_valid && in_ready) begin
      pending_results.push_back(divide_expected(in_data));
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: quotient %h remainder %h",
               out_data.quotient, out_data.remainder);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.quotient !== want.quotient) begin
          $error("quotient: expected %h, actual %h", want.quotient, out_data.quotient);
          mismatch_count++;
        end
        if (out_data.remainder !== want.remainder) begin
          $error("remainder: expected %h, actual %h", want.remainder, out_data.remainder);
          mismatch_count++;
        end
      end
    end
  end

  // Offers one operand beat and returns at the edge it is taken. in_valid
  // stays high on return, so back-to-back beats never drop it.
  task automatic send_operands(input logic [FIELD_W-1:0] dividend,
                               input logic [FIELD_W-1:0] divisor);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data.dividend <= dividend;
    in_data.divisor  <= divisor;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops offering beats until the pipeline has handed back everything.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Operand of random magnitude: spreads quotients across all bit lengths.
  function automatic logic [FIELD_W-1:0] random_operand();
    int unsigned      nbits;
    logic [FIELD_W-1:0] v;
    nbits = $urandom_range(FIELD_W, 0);
    v     = $urandom;
    if (nbits < FIELD_W) v = v & ((32'd1 << nbits) - 32'd1);
    return v;
  endfunction

  // Field extremes, zero divisor, divisor above dividend, equal operands,
  // top-bit dividends where the extra remainder bit matters.
  task automatic test_directed();
    send_operands(32'h0000_0000, 32'h0000_0000);
    send_operands(32'h0000_0000, 32'h0000_0001);
    send_operands(32'h0000_0000, 32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFF, 32'h0000_0000);
    send_operands(32'h1234_5678, 32'h0000_0000);
    send_operands(32'hFFFF_FFFF, 32'h0000_0001);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operands(32'h0000_0001, 32'hFFFF_FFFF);
    send_operands(32'h0000_0001, 32'h0000_0001);
    send_operands(32'h8000_0000, 32'h0000_0001);
    send_operands(32'h8000_0000, 32'h8000_0000);
    send_operands(32'h7FFF_FFFF, 32'h8000_0000);
    send_operands(32'hFFFF_FFFF, 32'h8000_0000);
    send_operands(32'hFFFF_FFFF, 32'h0000_0002);
    send_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_operands(32'hAAAA_AAAA, 32'h5555_5555);
    send_operands(32'h5555_5555, 32'hAAAA_AAAA);
    send_operands(32'h0000_0100, 32'h0000_0007);
    send_operands(32'hDEAD_BEEF, 32'h0000_0010);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    repeat (count) begin
      a = random_operand();
      case ($urandom_range(15))
        0:       b = '0;
        1:       b = a;
        2:       begin a = '1; b = random_operand(); end
        3:       b = $urandom;
        default: b = random_operand();
      endcase
      send_operands(a, b);
    end
  endtask

  // Burst, full drain with the sender parked, then another burst into an
  // empty pipeline.
  task automatic test_drain_pause();
    test_random_traffic(40);
    wait_drained();
    test_random_traffic(40);
  endtask

  initial begin
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 26;
    recv_idle_pct = 54;
    test_directed();
    test_random_traffic(260);

    send_idle_pct = 54;
    recv_idle_pct = 26;
    test_drain_pause();
    test_random_traffic(220);

    // No idling on either side: full-rate streaming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(300);

    wait_drained();
    // Quiet time: anything the pipeline still emits is flagged as unexpected.
    repeat (2 * LATENCY + 8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[restoring_divider_top] OK");
    end else begin
      $display("[restoring_divider_top] ERROR");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * WATCHDOG_CYCLES);
    $display("[restoring_divider_top] ERROR");
    $finish;
  end

endmodule
